>>> hw/rtl/sbb_pkg.sv
`default_nettype none
package sbb_pkg;

  localparam int PIX_W        = 24;
  localparam int OUT_COL_W    = 11;
  localparam int OUT_ROW_W    = 12;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 13;
  localparam int FRAME_W_W    = 12;
  localparam int FRAME_H_W    = 13;
  localparam int MIN_SIZE     = 3;
  localparam int RST_FRAME_W  = 640;
  localparam int RST_FRAME_H  = 480;
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // what the column pass has to do for one row-blurred value
  typedef struct packed {
    logic first;   // result for the row above
    logic div2;    // that result averages two rows only
    logic second;  // result for the current (last) row
    logic done;    // last result of the frame
  } sbb_job_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic                 done;
  } sbb_result_t;

  typedef struct packed {
    logic [1:0]  n;
    sbb_result_t r0;
    sbb_result_t r1;
  } sbb_push_t;

  // floor(s / 3) for s up to 765 by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [20:0] m;
    m = 21'(s) * 21'(683);
    return m[18:11];
  endfunction

  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    logic [8:0]       s;
    r = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s = {1'b0, a[ch*8 +: 8]} + {1'b0, b[ch*8 +: 8]};
      r[ch*8 +: 8] = s[8:1];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] avg3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] r;
    logic [9:0]       s;
    r = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s = {2'b0, a[ch*8 +: 8]} + {2'b0, b[ch*8 +: 8]} + {2'b0, c[ch*8 +: 8]};
      r[ch*8 +: 8] = div3(s);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sbb_if.sv
`default_nettype none
interface sbb_pix_if import sbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface sbb_res_if import sbb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     pixel_out;
  logic [OUT_COL_W-1:0] out_col;
  logic [OUT_ROW_W-1:0] out_row;
  logic                 frame_done;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output frame_done, input ready);
  modport sink (input valid, input pixel_out, input out_col, input out_row,
                input frame_done, output ready);
endinterface

interface sbb_cfg_if import sbb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sbb_hpass.sv
`default_nettype none
module sbb_hpass import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  sbb_pix_if.sink           pix,
  sbb_cfg_if.sink           cfg,
  output logic              job_valid,
  input  wire logic         job_ready,
  output sbb_job_ctl_t      job_ctl,
  output logic [CW-1:0]     job_col,
  output logic [RW-1:0]     job_row,
  output logic [PIX_W-1:0]  job_hv
);

  localparam int W_RST = (RST_FRAME_W > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_W;
  localparam int H_RST = (RST_FRAME_H > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_H;

  logic [CW-1:0]    w_last;
  logic [RW-1:0]    h_last;
  logic [CW-1:0]    x;
  logic [RW-1:0]    y;
  logic [PIX_W-1:0] prev1;
  logic [PIX_W-1:0] prev2;
  logic [1:0]       njobs;

  sbb_job_ctl_t     ctl0, ctl1;
  logic [CW-1:0]    col0, col1;
  logic [PIX_W-1:0] hv0, hv1;

  logic             cfg_wr;
  logic             restart;
  logic [CW-1:0]    w_last_cfg;
  logic [RW-1:0]    h_last_cfg;
  logic             accept;
  logic             pop;
  logic             has_a;
  logic             has_b;
  logic             last_row;
  sbb_job_ctl_t     ctl_a, ctl_b;
  logic [PIX_W-1:0] hv_a, hv_b;

  always_comb begin
    int wv;
    int hv;
    wv = int'(cfg.data[FRAME_W_W-1:0]);
    hv = int'(cfg.data[FRAME_H_W-1:0]);
    if (wv < MIN_SIZE) wv = MIN_SIZE;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv < MIN_SIZE) hv = MIN_SIZE;
    if (hv > MAX_HEIGHT) hv = MAX_HEIGHT;
    w_last_cfg = CW'(wv - 1);
    h_last_cfg = RW'(hv - 1);
  end

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign restart   = cfg_wr && (cfg.index == CFG_FRAME_WIDTH || cfg.index == CFG_FRAME_HEIGHT);

  assign job_valid = (njobs != 2'd0);
  assign pop       = job_valid && job_ready;
  assign pix.ready = (njobs == 2'd0) || (njobs == 2'd1 && job_ready);
  assign accept    = pix.valid && pix.ready;

  assign has_a    = (x != '0);
  assign has_b    = (x == w_last);
  assign last_row = (y == h_last);

  // x == 1 is the left edge, where only two pixels exist
  assign hv_a = (x == CW'(1)) ? avg2(prev1, pix.pixel_in)
                              : avg3(prev2, prev1, pix.pixel_in);
  assign hv_b = avg2(prev1, pix.pixel_in);

  always_comb begin
    ctl_a.first  = (y != '0);
    ctl_a.div2   = (y == RW'(1));
    ctl_a.second = last_row;
    ctl_a.done   = 1'b0;
    ctl_b        = ctl_a;
    ctl_b.done   = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= CW'(W_RST - 1);
      h_last <= RW'(H_RST - 1);
      x      <= '0;
      y      <= '0;
      prev1  <= '0;
      prev2  <= '0;
      njobs  <= 2'd0;
    end else if (restart) begin
      if (cfg.index == CFG_FRAME_WIDTH) w_last <= w_last_cfg;
      else h_last <= h_last_cfg;
      x     <= '0;
      y     <= '0;
      prev1 <= '0;
      prev2 <= '0;
    end else begin
      if (pop) njobs <= njobs - 2'd1;
      if (accept) begin
        njobs <= {1'b0, has_a} + {1'b0, has_b};
        if (has_b) begin
          x     <= '0;
          prev1 <= '0;
          prev2 <= '0;
          y     <= last_row ? '0 : y + RW'(1);
        end else begin
          x     <= x + CW'(1);
          prev1 <= pix.pixel_in;
          prev2 <= prev1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ctl0 <= ctl1;
      col0 <= col1;
      hv0  <= hv1;
    end
    if (accept) begin
      ctl0    <= ctl_a;
      col0    <= x - CW'(1);
      hv0     <= hv_a;
      ctl1    <= ctl_b;
      col1    <= x;
      hv1     <= hv_b;
      job_row <= y;
    end
  end

  assign job_ctl = ctl0;
  assign job_col = col0;
  assign job_hv  = hv0;

`ifndef NO_ASSERTIONS
  a_second_has_first: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ctl.second |-> job_ctl.first)
    else $error("last-row job without row-above result");
  a_accept_empties: assert property (@(posedge clk) disable iff (rst)
    accept && !restart && has_b |=> njobs == 2'd2)
    else $error("row-end pixel did not queue two column updates");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/sbb_vpass.sv
`default_nettype none
module sbb_vpass import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 job_valid,
  output logic                      job_ready,
  input  wire sbb_job_ctl_t         job_ctl,
  input  wire logic [CW-1:0]        job_col,
  input  wire logic [RW-1:0]        job_row,
  input  wire logic [PIX_W-1:0]     job_hv,
  input  wire logic [OUT_CNT_W-1:0] fifo_count,
  output sbb_push_t                 push
);

  // each entry holds {two rows above, one row above}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  logic               s2_valid;
  sbb_job_ctl_t       s2_ctl;
  logic [CW-1:0]      s2_col;
  logic [RW-1:0]      s2_row;
  logic [PIX_W-1:0]   s2_hv;
  logic [2*PIX_W-1:0] rd_data;

  logic               take;
  logic [1:0]         s2_n;
  logic [OUT_CNT_W:0] need;
  logic [PIX_W-1:0]   above1, above2;
  logic [RW-1:0]      row_up;
  logic [CW+OUT_COL_W-1:0] col_ext;
  logic [RW+OUT_ROW_W-1:0] row_ext, row_up_ext;

  assign s2_n = s2_valid ? ({1'b0, s2_ctl.first} + {1'b0, s2_ctl.second}) : 2'd0;
  // room for this job's results once the stage ahead has pushed
  assign need = {1'b0, fifo_count} + (OUT_CNT_W + 1)'(s2_n) + (OUT_CNT_W + 1)'(2);
  assign job_ready = (need <= (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign take = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= take;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_ctl <= job_ctl;
      s2_col <= job_col;
      s2_row <= job_row;
      s2_hv  <= job_hv;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rd_data <= line_mem[job_col];
    if (s2_valid) line_mem[s2_col] <= {rd_data[PIX_W-1:0], s2_hv};
  end

  assign above1     = rd_data[PIX_W-1:0];
  assign above2     = rd_data[2*PIX_W-1:PIX_W];
  assign row_up     = s2_row - RW'(1);
  assign col_ext    = {{OUT_COL_W{1'b0}}, s2_col};
  assign row_ext    = {{OUT_ROW_W{1'b0}}, s2_row};
  assign row_up_ext = {{OUT_ROW_W{1'b0}}, row_up};

  always_comb begin
    push.n        = s2_n;
    push.r0.pixel = s2_ctl.div2 ? avg2(above1, s2_hv) : avg3(above2, above1, s2_hv);
    push.r0.col   = col_ext[OUT_COL_W-1:0];
    push.r0.row   = row_up_ext[OUT_ROW_W-1:0];
    push.r0.done  = 1'b0;
    push.r1.pixel = avg2(above1, s2_hv);
    push.r1.col   = col_ext[OUT_COL_W-1:0];
    push.r1.row   = row_ext[OUT_ROW_W-1:0];
    push.r1.done  = s2_ctl.done;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> ({1'b0, fifo_count} + (OUT_CNT_W + 1)'(s2_n)) <=
                 (OUT_CNT_W + 1)'(OUT_DEPTH))
    else $error("column pass pushed into a full result queue");
  a_no_rmw_clash: assert property (@(posedge clk) disable iff (rst)
    s2_valid && take |-> job_col != s2_col)
    else $error("line buffer read of the entry being written back");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/sbb_out_fifo.sv
`default_nettype none
module sbb_out_fifo import sbb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sbb_push_t            push,
  output logic [OUT_CNT_W-1:0]      count,
  sbb_res_if.source                 res
);

  sbb_result_t              slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]     wr_ptr;
  logic [OUT_PTR_W-1:0]     rd_ptr;
  logic                     pop;
  sbb_result_t              head;

  assign pop  = res.valid && res.ready;
  assign head = slots[rd_ptr];

  assign res.valid      = (count != '0);
  assign res.pixel_out  = head.pixel;
  assign res.out_col    = head.col;
  assign res.out_row    = head.row;
  assign res.frame_done = head.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(push.n);
      if (pop) rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      count <= count + OUT_CNT_W'(push.n) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) slots[wr_ptr] <= push.r0;
    if (push.n == 2'd2) slots[wr_ptr + OUT_PTR_W'(1)] <= push.r1;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !pop && push.n == 2'd0 |=> $stable(count))
    else $error("result queue count moved without push or pop");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/separable_box_blur_3x3_core.sv
`default_nettype none
// each result passes the row-pass job slots, the column stage and the result queue
// throughput: one pixel per cycle while jobs are taken; a row's last pixel holds the input
// until both its column updates pass the single read-modify-write port of the line buffer
// last row of a frame: two results per pixel, sent at one result per cycle while res.ready
// reset: counters and pixel window cleared, size 640 x 480, result queue empty;
// line buffer contents are left as they are (no clearing pass)
module separable_box_blur_3x3_core import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input wire logic  clk,
  input wire logic  rst,
  sbb_pix_if.sink   pix,
  sbb_cfg_if.sink   cfg,
  sbb_res_if.source res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic                 job_valid;
  logic                 job_ready;
  sbb_job_ctl_t         job_ctl;
  logic [CW-1:0]        job_col;
  logic [RW-1:0]        job_row;
  logic [PIX_W-1:0]     job_hv;
  logic [OUT_CNT_W-1:0] fifo_count;
  sbb_push_t            push;

  sbb_hpass #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_hpass (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .cfg      (cfg),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job_ctl  (job_ctl),
    .job_col  (job_col),
    .job_row  (job_row),
    .job_hv   (job_hv)
  );

  sbb_vpass #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_vpass (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_ctl   (job_ctl),
    .job_col   (job_col),
    .job_row   (job_row),
    .job_hv    (job_hv),
    .fifo_count(fifo_count),
    .push      (push)
  );

  sbb_out_fifo u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .count(fifo_count),
    .res  (res)
  );

endmodule
`default_nettype wire
